// File: rtl/cv_gaussian_component_predict_assert.svh
// Assertion macros used by the checker of the component prediction block.
`ifndef CV_GAUSSIAN_COMPONENT_PREDICT_ASSERT_SVH
`define CV_GAUSSIAN_COMPONENT_PREDICT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/gcp_pkg.sv
// Shared types, constants and register codes of the component prediction block.
package gcp_pkg;

    localparam int FRAC_BITS_DEF = 16;
    // Width that holds the exact product of a 31-bit unsigned and a 32-bit signed value.
    localparam int PROD_FULL_W = 63;
    // The survival probability is always unsigned Q1.16.
    localparam int PROB_FRAC = 16;

    localparam int REG_IDX_W = 3;
    localparam int REG_DATA_W = 31;

    localparam logic [REG_IDX_W-1:0] REG_SURVIVAL  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TIME_STEP = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_PX  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_PY  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_VX  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_VY  = 3'd5;

    localparam logic [16:0] SURVIVAL_RST  = 17'd62259;
    localparam logic [30:0] TIME_STEP_RST = 31'd65536;
    localparam logic [30:0] NOISE_RST     = 31'd6554;

    localparam logic [1:0] LAST_ROW = 2'd3;

    localparam logic signed [31:0] SAT_HI = 32'sh7FFFFFFF;
    localparam logic signed [31:0] SAT_LO = 32'sh80000000;
    localparam logic [30:0] W31_MAX = 31'h7FFFFFFF;

    typedef enum logic [2:0] {
        S_LOAD,
        S_MUL1,
        S_ADD1,
        S_MUL2,
        S_SUM
    } gcp_state_t;

    typedef struct packed {
        logic       mul1;
        logic       add1;
        logic       mul2;
        logic       sum;
        logic [1:0] row;
    } gcp_ctl_t;

endpackage

// File: rtl/cv_gaussian_component_predict.sv
// Top level of the constant-velocity Gaussian component prediction block.
// Input rows are taken one per cycle while the block is loading; the row with index 3
// starts the prediction, and the input stalls until the last result row has entered
// the output register. Each result row passes the states MUL1, ADD1, MUL2 and SUM, waits
// in SUM while the output register is full, and uses the one multiplier of each lane twice.
// Reset is asynchronous: registers return to defaults, the weight clears, the stores stay.
module cv_gaussian_component_predict
    import gcp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [REG_IDX_W-1:0]   wr_index,
    input  logic [REG_DATA_W-1:0]  wr_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             row_index,
    input  logic [30:0]            comp_weight,
    input  logic signed [31:0]     state_value,
    input  logic signed [31:0]     cov_col0,
    input  logic signed [31:0]     cov_col1,
    input  logic signed [31:0]     cov_col2,
    input  logic signed [31:0]     cov_col3,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             out_row,
    output logic [30:0]            out_weight,
    output logic signed [31:0]     out_state,
    output logic signed [31:0]     out_cov0,
    output logic signed [31:0]     out_cov1,
    output logic signed [31:0]     out_cov2,
    output logic signed [31:0]     out_cov3,
    output logic                   last_row
);

    localparam int RW = PROD_FULL_W - FRAC_BITS;

    logic [16:0]        surv_reg;
    logic [30:0]        ts_reg;
    logic [30:0]        noise_reg [4];
    logic [30:0]        held_w_reg;
    logic signed [31:0] cov_reg [4][4];
    logic signed [31:0] st_reg [4];

    gcp_ctl_t           ctl;
    logic               in_acc;
    logic               out_free;
    logic               out_valid_reg;
    logic [1:0]         out_row_reg;
    logic [30:0]        out_weight_reg;
    logic signed [31:0] out_state_reg;
    logic signed [31:0] out_cov_reg [4];

    logic signed [RW-1:0] diag;
    logic [30:0]          weight;
    logic signed [31:0]   lane_a [4];
    logic signed [31:0]   lane_res [4];
    logic signed [31:0]   st_a;
    logic signed [31:0]   st_res;
    logic signed [31:0]   col_in [4];

    assign in_acc = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surv_reg <= SURVIVAL_RST;
            ts_reg <= TIME_STEP_RST;
            for (int k = 0; k < 4; k++)
                noise_reg[k] <= NOISE_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_SURVIVAL:  surv_reg <= wr_data[16:0];
                REG_TIME_STEP: ts_reg <= wr_data;
                REG_NOISE_PX:  noise_reg[0] <= wr_data;
                REG_NOISE_PY:  noise_reg[1] <= wr_data;
                REG_NOISE_VX:  noise_reg[2] <= wr_data;
                REG_NOISE_VY:  noise_reg[3] <= wr_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            held_w_reg <= '0;
        else if (in_acc && row_index == 2'd0)
            held_w_reg <= comp_weight;
    end

    assign col_in[0] = cov_col0;
    assign col_in[1] = cov_col1;
    assign col_in[2] = cov_col2;
    assign col_in[3] = cov_col3;

    // Each finished output row rotates the stores by one row, so the lanes always read
    // the current row at slot 0 and the row two below it at slot 2. Four rotations
    // restore the original order.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            st_reg[row_index] <= state_value;
            for (int c = 0; c < 4; c++)
                cov_reg[row_index][c] <= col_in[c];
        end
        else if (ctl.sum)
        begin
            for (int r = 0; r < 4; r++)
            begin
                st_reg[r] <= st_reg[2'(r + 1)];
                for (int c = 0; c < 4; c++)
                    cov_reg[r][c] <= cov_reg[2'(r + 1)][c];
            end
        end
    end

    gcp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (row_index == LAST_ROW),
        .out_free (out_free),
        .in_stall (in_stall),
        .ctl      (ctl)
    );

    gcp_scale #(
        .FRAC_BITS (FRAC_BITS)
    ) u_scale (
        .clk       (clk),
        .en        (ctl.mul1),
        .time_step (ts_reg),
        .noise     (noise_reg[ctl.row]),
        .prob      (surv_reg),
        .held_w    (held_w_reg),
        .diag      (diag),
        .weight    (weight)
    );

    // Position columns merge in the velocity column of the same row.
    for (genvar j = 0; j < 4; j++)
    begin : g_lane
        gcp_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk       (clk),
            .ctl       (ctl),
            .time_step (ts_reg),
            .top       (cov_reg[0][j]),
            .low       (cov_reg[2][j]),
            .partner   ((j < 2) ? lane_a[(j + 2) % 4] : 32'sd0),
            .diag      (diag),
            .diag_en   (ctl.row == 2'(j)),
            .a         (lane_a[j]),
            .res       (lane_res[j])
        );
    end

    gcp_lane #(
        .FRAC_BITS (FRAC_BITS)
    ) u_state_lane (
        .clk       (clk),
        .ctl       (ctl),
        .time_step (ts_reg),
        .top       (st_reg[0]),
        .low       (st_reg[2]),
        .partner   (32'sd0),
        .diag      (diag),
        .diag_en   (1'b0),
        .a         (st_a),
        .res       (st_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.sum)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.sum)
        begin
            out_row_reg <= ctl.row;
            out_weight_reg <= weight;
            // The state lane ends at its first sum; its final stage only repeats it.
            out_state_reg <= (st_a == st_res) ? st_a : st_res;
            for (int c = 0; c < 4; c++)
                out_cov_reg[c] <= lane_res[c];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row = out_row_reg;
    assign out_weight = out_weight_reg;
    assign out_state = out_state_reg;
    assign out_cov0 = out_cov_reg[0];
    assign out_cov1 = out_cov_reg[1];
    assign out_cov2 = out_cov_reg[2];
    assign out_cov3 = out_cov_reg[3];
    assign last_row = (out_row_reg == LAST_ROW);

endmodule

// File: rtl/gcp_lane.sv
// One column lane: forms the F*P entry and then the predicted covariance entry.
module gcp_lane
    import gcp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  gcp_ctl_t                               ctl,
    input  logic [30:0]                            time_step,
    input  logic signed [31:0]                     top,
    input  logic signed [31:0]                     low,
    input  logic signed [31:0]                     partner,
    input  logic signed [PROD_FULL_W-FRAC_BITS-1:0] diag,
    input  logic                                   diag_en,
    output logic signed [31:0]                     a,
    output logic signed [31:0]                     res
);

    localparam int RW = PROD_FULL_W - FRAC_BITS;
    localparam int AW = RW + 1;
    localparam int SW = RW + 2;
    localparam logic signed [PROD_FULL_W-1:0] RND = PROD_FULL_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [AW-1:0] A_HI = AW'(SAT_HI);
    localparam logic signed [AW-1:0] A_LO = AW'(SAT_LO);
    localparam logic signed [SW-1:0] S_HI = SW'(SAT_HI);
    localparam logic signed [SW-1:0] S_LO = SW'(SAT_LO);

    logic signed [31:0]            mul_op;
    logic signed [PROD_FULL_W-1:0] mul_full;
    logic signed [PROD_FULL_W-1:0] mul_sh;
    logic signed [RW-1:0]          mul_rnd;
    logic signed [RW-1:0]          prod_reg;
    logic signed [RW-1:0]          prod_used;
    logic signed [RW-1:0]          diag_used;
    logic signed [AW-1:0]          a_sum;
    logic signed [31:0]            a_sat;
    logic signed [31:0]            a_reg;
    logic signed [SW-1:0]          res_sum;

    always_comb
    begin
        // The shared multiplier scales the lower row first and the partner lane second.
        mul_op = ctl.mul2 ? partner : low;
        mul_full = $signed({1'b0, time_step}) * mul_op;
        mul_sh = (mul_full + RND) >>> FRAC_BITS;
        mul_rnd = mul_sh[RW-1:0];

        // Only the position rows pick up the velocity term.
        prod_used = ctl.row[1] ? '0 : prod_reg;
        a_sum = AW'(top) + AW'(prod_used);
        if (a_sum > A_HI)
            a_sat = SAT_HI;
        else if (a_sum < A_LO)
            a_sat = SAT_LO;
        else
            a_sat = a_sum[31:0];

        diag_used = diag_en ? diag : '0;
        res_sum = SW'(a_reg) + SW'(prod_reg) + SW'(diag_used);
        if (res_sum > S_HI)
            res = SAT_HI;
        else if (res_sum < S_LO)
            res = SAT_LO;
        else
            res = res_sum[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul1 || ctl.mul2)
            prod_reg <= mul_rnd;
        if (ctl.add1)
            a_reg <= a_sat;
    end

    assign a = a_reg;

endmodule

// File: rtl/gcp_scale.sv
// Weight scaling by the survival probability and the time-scaled noise term.
module gcp_scale
    import gcp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                   clk,
    input  logic                                   en,
    input  logic [30:0]                            time_step,
    input  logic [30:0]                            noise,
    input  logic [16:0]                            prob,
    input  logic [30:0]                            held_w,
    output logic signed [PROD_FULL_W-FRAC_BITS-1:0] diag,
    output logic [30:0]                            weight
);

    localparam int RW = PROD_FULL_W - FRAC_BITS;
    localparam int WW = 49;
    localparam logic signed [PROD_FULL_W-1:0] RND = PROD_FULL_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic [WW-1:0] PROB_RND = WW'(1) << (PROB_FRAC - 1);

    logic signed [PROD_FULL_W-1:0] mul_full;
    logic signed [PROD_FULL_W-1:0] mul_sh;
    logic [WW-1:0]                 w_full;
    logic [32:0]                   w_sh;
    logic [30:0]                   w_sat;
    logic signed [RW-1:0]          diag_reg;
    logic [30:0]                   weight_reg;

    always_comb
    begin
        mul_full = $signed({1'b0, time_step}) * $signed({1'b0, noise});
        mul_sh = (mul_full + RND) >>> FRAC_BITS;
        w_full = WW'(prob) * WW'(held_w) + PROB_RND;
        w_sh = w_full[PROB_FRAC +: 33];
        w_sat = (w_sh[32:31] != 2'b00) ? W31_MAX : w_sh[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diag_reg <= mul_sh[RW-1:0];
            weight_reg <= w_sat;
        end
    end

    assign diag = diag_reg;
    assign weight = weight_reg;

endmodule

// File: rtl/gcp_ctrl.sv
// Sequencer: takes input rows until the one with index 3, then steps the lanes through each output row.
module gcp_ctrl
    import gcp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    input  logic     out_free,
    output logic     in_stall,
    output gcp_ctl_t ctl
);

    gcp_state_t state_reg;
    gcp_state_t state_next;
    logic [1:0] row_reg;
    logic [1:0] row_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            row_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg <= row_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        row_next = row_reg;
        in_stall = 1'b1;
        ctl = '0;
        ctl.row = row_reg;
        case (state_reg)
            S_LOAD:
            begin
                in_stall = 1'b0;
                if (in_valid && in_last)
                begin
                    state_next = S_MUL1;
                    row_next = '0;
                end
            end
            S_MUL1:
            begin
                ctl.mul1 = 1'b1;
                state_next = S_ADD1;
            end
            S_ADD1:
            begin
                ctl.add1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                ctl.mul2 = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                // Hold the finished row until the output register has room.
                if (out_free)
                begin
                    ctl.sum = 1'b1;
                    row_next = row_reg + 2'd1;
                    state_next = (row_reg == LAST_ROW) ? S_LOAD : S_MUL1;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

endmodule

// File: rtl/gcp_checker.sv
// Port-level checker for the component prediction block and its bind.
`include "cv_gaussian_component_predict_assert.svh"

module gcp_checker
    import gcp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic [1:0]         row_index,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         out_row,
    input logic signed [31:0] out_state,
    input logic signed [31:0] out_cov0,
    input logic               last_row
);

    // A stalled result keeps its row, its state and its first covariance value.
    `GCP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_row) && $stable(out_state) && $stable(out_cov0), "stalled result changed")

    // The final flag marks exactly the fourth result row.
    `GCP_ASSERT_NOW(a_last_flag, out_valid, last_row == (out_row == LAST_ROW), "last_row flag and out_row disagree")

    // No new row is taken while a component is still being emitted.
    `GCP_ASSERT_NOW(a_busy_stall, out_valid && !last_row, in_stall, "input taken during emission")

    // A taken result row of a component is followed by nothing or by the next row.
    `GCP_ASSERT_NEXT(a_row_next, out_valid && !out_stall && !last_row, !out_valid || out_row == $past(out_row) + 2'd1, "result rows out of order")

    // Taking the final row starts the prediction and closes the input.
    `GCP_ASSERT_NEXT(a_final_stall, in_valid && !in_stall && row_index == LAST_ROW, in_stall, "input open after final row")

endmodule

bind cv_gaussian_component_predict gcp_checker u_gcp_checker (.*);

// File: verif/tb_cv_gaussian_component_predict.sv
// Self-checking testbench for the constant-velocity Gaussian component prediction block.
`timescale 1ns / 100ps

module tb_cv_gaussian_component_predict;
    import gcp_pkg::*;

    localparam int FRAC = FRAC_BITS_DEF;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 3000;

    // Indexes past the last register; writes to them must have no effect.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [1:0]       row;
        logic [30:0]      weight;
        logic [31:0]      st;
        logic [3:0][31:0] cov;
        logic             last;
    } comp_row_t;

    // Keeps its own copy of the registers and row stores and predicts the four output rows.
    class component_predictor;
        logic [16:0] survival;
        logic [30:0] tstep;
        logic [30:0] noise [4];
        longint      cov_slot [16];
        longint      state_slot [4];
        logic [30:0] weight_held;
        comp_row_t   predicted_rows [$];
        int          errors;

        function new();
            survival = SURVIVAL_RST;
            tstep = TIME_STEP_RST;
            for (int i = 0; i < 4; i++)
            begin
                noise[i] = NOISE_RST;
                state_slot[i] = 0;
            end
            for (int i = 0; i < 16; i++)
            begin
                cov_slot[i] = 0;
            end
            weight_held = '0;
            errors = 0;
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] data);
            case (idx)
                REG_SURVIVAL:  survival = data[16:0];
                REG_TIME_STEP: tstep = data;
                REG_NOISE_PX:  noise[0] = data;
                REG_NOISE_PY:  noise[1] = data;
                REG_NOISE_VX:  noise[2] = data;
                REG_NOISE_VY:  noise[3] = data;
                default: ;
            endcase
        endfunction

        // Exact product, rounded half up, back to the fixed-point scale.
        function longint scale(longint a, longint b);
            return (a * b + (longint'(1) << (FRAC - 1))) >>> FRAC;
        endfunction

        function longint clamp(longint v);
            if (v > longint'(SAT_HI))
                return longint'(SAT_HI);
            if (v < longint'(SAT_LO))
                return longint'(SAT_LO);
            return v;
        endfunction

        function void take_row(comp_row_t item);
            longint    a [4][4];
            longint    acc [4];
            longint    sv;
            longint    wt;
            longint    ts;
            comp_row_t res;
            int        r;
            r = item.row;
            if (item.row == 2'd0)
                weight_held = item.weight;
            state_slot[r] = longint'($signed(item.st));
            for (int j = 0; j < 4; j++)
            begin
                cov_slot[r * 4 + j] = longint'($signed(item.cov[j]));
            end
            if (item.row != LAST_ROW)
                return;

            wt = (longint'(survival) * longint'(weight_held)
                  + (longint'(1) << (PROB_FRAC - 1))) >>> PROB_FRAC;
            if (wt > longint'(W31_MAX))
                wt = longint'(W31_MAX);
            ts = longint'(tstep);

            // The velocity rows of F*P pass through; the position rows pick up dt times velocity.
            for (int j = 0; j < 4; j++)
            begin
                a[0][j] = clamp(cov_slot[j] + scale(ts, cov_slot[8 + j]));
                a[1][j] = clamp(cov_slot[4 + j] + scale(ts, cov_slot[12 + j]));
                a[2][j] = cov_slot[8 + j];
                a[3][j] = cov_slot[12 + j];
            end

            for (int i = 0; i < 4; i++)
            begin
                acc[0] = a[i][0] + scale(ts, a[i][2]);
                acc[1] = a[i][1] + scale(ts, a[i][3]);
                acc[2] = a[i][2];
                acc[3] = a[i][3];
                acc[i] += scale(ts, longint'(noise[i]));
                if (i < 2)
                    sv = state_slot[i] + scale(ts, state_slot[i + 2]);
                else
                    sv = state_slot[i];
                res.row = 2'(i);
                res.weight = 31'(wt);
                res.st = 32'(clamp(sv));
                for (int j = 0; j < 4; j++)
                begin
                    res.cov[j] = 32'(clamp(acc[j]));
                end
                res.last = (i == 3);
                predicted_rows = {predicted_rows, res};
            end
        endfunction

        function void match(string field, logic [1:0] row, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: row %0d %s mismatch, expected %h, actual %h",
                         $time, row, field, want, got);
            end
        endfunction

        function void check_row(comp_row_t got);
            comp_row_t want;
            if (predicted_rows.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output row %0d, expected none, actual state %h",
                         $time, got.row, got.st);
                return;
            end
            want = predicted_rows.pop_front();
            match("row", want.row, 32'(want.row), 32'(got.row));
            match("weight", want.row, 32'(want.weight), 32'(got.weight));
            match("state", want.row, want.st, got.st);
            match("cov0", want.row, want.cov[0], got.cov[0]);
            match("cov1", want.row, want.cov[1], got.cov[1]);
            match("cov2", want.row, want.cov[2], got.cov[2]);
            match("cov3", want.row, want.cov[3], got.cov[3]);
            match("last_row", want.row, 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  wr_en = 1'b0;
    logic [REG_IDX_W-1:0]  wr_index = '0;
    logic [REG_DATA_W-1:0] wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            row_index = '0;
    logic [30:0]           comp_weight = '0;
    logic signed [31:0]    state_value = '0;
    logic signed [31:0]    cov_col0 = '0;
    logic signed [31:0]    cov_col1 = '0;
    logic signed [31:0]    cov_col2 = '0;
    logic signed [31:0]    cov_col3 = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [1:0]            out_row;
    logic [30:0]           out_weight;
    logic signed [31:0]    out_state;
    logic signed [31:0]    out_cov0;
    logic signed [31:0]    out_cov1;
    logic signed [31:0]    out_cov2;
    logic signed [31:0]    out_cov3;
    logic                  last_row;

    component_predictor tracker;
    comp_row_t          offered;
    bit                 calm = 1'b0;
    bit                 hold_req = 1'b0;
    int                 quiet_cycles = 0;

    cv_gaussian_component_predict #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .wr_en(wr_en),
        .wr_index(wr_index),
        .wr_data(wr_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .row_index(row_index),
        .comp_weight(comp_weight),
        .state_value(state_value),
        .cov_col0(cov_col0),
        .cov_col1(cov_col1),
        .cov_col2(cov_col2),
        .cov_col3(cov_col3),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_row(out_row),
        .out_weight(out_weight),
        .out_state(out_state),
        .out_cov0(out_cov0),
        .out_cov1(out_cov1),
        .out_cov2(out_cov2),
        .out_cov3(out_cov3),
        .last_row(last_row)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        comp_row_t seen;
        if (rst_n && in_valid && !in_stall)
            tracker.take_row(offered);
        if (rst_n && out_valid && !out_stall)
        begin
            seen.row = out_row;
            seen.weight = out_weight;
            seen.st = out_state;
            seen.cov[0] = out_cov0;
            seen.cov[1] = out_cov1;
            seen.cov[2] = out_cov2;
            seen.cov[3] = out_cov3;
            seen.last = last_row;
            tracker.check_row(seen);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Output side: random stall bursts, quiet stretches, and one long hold-off on request.
    initial
    begin : receiver
        int pick;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pick = $urandom_range(0, 15);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!calm && pick < 2)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (pick == 2)
            begin
                repeat ($urandom_range(20, 60)) @(negedge clk);
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return SAT_HI;
            1: return SAT_LO;
            2: return 32'd0;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom;
            default: return 32'(int'($urandom_range(0, 13107200)) - 6553600);
        endcase
    endfunction

    function automatic logic [30:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return W31_MAX;
            1: return 31'd0;
            2, 3: return 31'($urandom);
            default: return 31'($urandom_range(0, 262144));
        endcase
    endfunction

    function automatic logic [30:0] pick_wide();
        if ($urandom_range(0, 3) == 0)
            return 31'($urandom);
        return 31'($urandom_range(0, 262144));
    endfunction

    function automatic comp_row_t make_row(logic [1:0] r);
        comp_row_t item;
        item.row = r;
        item.weight = pick_weight();
        item.st = pick_value();
        for (int j = 0; j < 4; j++)
        begin
            item.cov[j] = pick_value();
        end
        item.last = 1'b0;
        return item;
    endfunction

    function automatic comp_row_t uniform_row(logic [1:0] r, logic [30:0] w, logic [31:0] v);
        comp_row_t item;
        item.row = r;
        item.weight = w;
        item.st = v;
        item.cov = {v, v, v, v};
        item.last = 1'b0;
        return item;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item was taken.
    task automatic send_row(input comp_row_t item);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        offered = item;
        in_valid <= 1'b1;
        row_index <= item.row;
        comp_weight <= item.weight;
        state_value <= item.st;
        cov_col0 <= item.cov[0];
        cov_col1 <= item.cov[1];
        cov_col2 <= item.cov[2];
        cov_col3 <= item.cov[3];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_component();
        for (int r = 0; r < 4; r++)
        begin
            send_row(make_row(2'(r)));
        end
    endtask

    task automatic run_random(input int count);
        int sent;
        int n;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                send_component();
                sent += 4;
            end
            else
            begin
                // Broken sequences: rows out of order, repeated, or a lone final row.
                n = $urandom_range(1, 3);
                repeat (n) send_row(make_row(2'($urandom_range(0, 3))));
                sent += n;
            end
        end
    endtask

    // Waits until every predicted row has come out and the block has gone quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.predicted_rows.size() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(negedge clk);
        tracker.set_reg(idx, data);
    endtask

    task automatic load_config(input logic [16:0] surv, input logic [30:0] step,
                               input logic [30:0] npx, input logic [30:0] npy,
                               input logic [30:0] nvx, input logic [30:0] nvy);
        put_reg(REG_SURVIVAL, 31'(surv));
        put_reg(REG_TIME_STEP, step);
        put_reg(REG_NOISE_PX, npx);
        put_reg(REG_NOISE_PY, npy);
        put_reg(REG_NOISE_VX, nvx);
        put_reg(REG_NOISE_VY, nvy);
        put_reg(REG_SPARE_LO, 31'($urandom));
        put_reg(REG_SPARE_HI, 31'($urandom));
        wr_en <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_random_config();
        load_config(17'($urandom_range(0, 131071)), pick_wide(), pick_wide(), pick_wide(),
                    pick_wide(), pick_wide());
    endtask

    initial
    begin
        tracker = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed items under the reset settings. The first component fills every slot.
        send_component();
        for (int r = 0; r < 4; r++)
        begin
            send_row(uniform_row(2'(r), W31_MAX, SAT_HI));
        end
        for (int r = 0; r < 4; r++)
        begin
            send_row(uniform_row(2'(r), 31'd0, SAT_LO));
        end
        send_row(make_row(2'd2));
        send_row(make_row(2'd0));
        send_row(make_row(2'd1));
        send_row(make_row(LAST_ROW));
        send_row(make_row(2'd1));
        send_row(make_row(2'd1));
        send_row(make_row(LAST_ROW));
        send_row(make_row(LAST_ROW));
        send_row(make_row(2'd0));
        send_row(make_row(LAST_ROW));
        settle();

        // Largest settings: survival above one overflows the weight.
        load_config(17'h1FFFF, W31_MAX, W31_MAX, W31_MAX, W31_MAX, W31_MAX);
        run_random(40);
        settle();

        load_config(17'd0, 31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
        run_random(40);
        settle();

        // The output side holds off long enough for the block to stall its input.
        load_config(17'd65536, pick_wide(), pick_wide(), pick_wide(), pick_wide(), pick_wide());
        hold_req = 1'b1;
        run_random(50);
        settle();

        repeat (3)
        begin
            load_random_config();
            run_random(45);
            settle();
        end

        load_random_config();
        calm = 1'b1;
        run_random(30);
        settle();

        if (tracker.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
